// ----- rtl/mssp_pkg.sv -----
// Shared constants, codes and control types for the min-separation point placer.
`default_nettype none

package mssp_pkg;

   // default sizes
   localparam int MAX_POINTS_DEF = 1024;
   localparam int COORD_BITS_DEF = 16;

   // register port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_BOX_WIDTH     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_HEIGHT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_SEP_SQ    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ATTEMPT_LIMIT = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TARGET_COUNT  = 3'd4;

   localparam logic [15:0] BOX_WIDTH_RST     = 16'd65535;
   localparam logic [15:0] BOX_HEIGHT_RST    = 16'd65535;
   localparam logic [31:0] MIN_SEP_SQ_RST    = 32'd0;
   localparam logic [15:0] ATTEMPT_LIMIT_RST = 16'd1000;
   localparam logic [10:0] TARGET_COUNT_RST  = 11'd1024;

   // result status codes
   localparam int STATUS_W = 3;
   localparam logic [STATUS_W-1:0] STAT_ACCEPTED = 3'd0;
   localparam logic [STATUS_W-1:0] STAT_REJECTED = 3'd1;
   localparam logic [STATUS_W-1:0] STAT_FAILED   = 3'd2;
   localparam logic [STATUS_W-1:0] STAT_DONE     = 3'd3;
   localparam logic [STATUS_W-1:0] STAT_CLEARED  = 3'd4;

   typedef struct packed {
      logic [15:0] box_width;
      logic [15:0] box_height;
      logic [31:0] min_sep_sq;
      logic [15:0] attempt_limit;
      logic [10:0] target_count;
   } cfg_type;

   // controller -> datapath
   typedef struct packed {
      logic load;        // capture the incoming transaction
      logic scan_start;  // rewind the store scan
      logic scan_step;   // read one stored point into the distance pipe
      logic commit;      // update counters, store point, form the result
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic skip;        // no scan needed (clear, failed, done or empty store)
      logic scan_last;   // current scan address is the last stored point
      logic pipe_busy;   // distance pipe still holds compares
   } stat_type;

endpackage

`default_nettype wire

// ----- rtl/min_separation_point_placer.sv -----
// Top level of the min-separation point placer: ports, register file, result register.
//
// Usage:
//  - req channel: one transaction per candidate point or clear command.
//    req_tuser is the action (0 offer candidate, 1 clear and restart),
//    req_tdata carries cand_x (low) and cand_y (high).
//  - rsp channel: exactly one transaction per request, in order.
//    rsp_tuser is the status (accepted, rejected, failed, done, cleared),
//    rsp_tdata carries point_index, placed_total and done_res.
//  - csr port: write-only, one register per index, taken on any cycle
//    with csr_we high; write only while no request is in progress.
//  - Timing: an offer is compared against every stored point through a
//    single read port and a 5-stage distance pipe, one point per cycle.
//    With n points stored, rsp_tvalid rises once all n compares have
//    drained; clear, failed, done and empty-store answers skip the scan.
//  - Stall: the result register holds while rsp_tready is low; the next
//    request is accepted meanwhile and waits at commit for the register.
//  - Reset: clears counters, failure flag, pipe and handshakes and loads
//    register defaults. Stored coordinates need no clearing; only entries
//    below the placed count are ever read.
`default_nettype none

module min_separation_point_placer #(
   parameter int MAX_POINTS = mssp_pkg::MAX_POINTS_DEF,
   parameter int COORD_BITS = mssp_pkg::COORD_BITS_DEF,
   localparam int IDX_W = $clog2(MAX_POINTS),
   localparam int CNT_W = $clog2(MAX_POINTS + 1),
   localparam int REQ_W = ((2 * COORD_BITS + 7) / 8) * 8,
   localparam int RSP_W = ((IDX_W + CNT_W + 1 + 7) / 8) * 8
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   // request channel
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   input  wire logic [REQ_W-1:0]                   req_tdata,  // cand_x, cand_y
   input  wire logic                               req_tuser,  // action
   // response channel
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   output logic [RSP_W-1:0]                        rsp_tdata,  // point_index, placed_total, done_res
   output logic [mssp_pkg::STATUS_W-1:0]           rsp_tuser,  // status
   // register write port
   input  wire logic                               csr_we,
   input  wire logic [mssp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [mssp_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   mssp_pkg::cfg_type  cfg_ff;
   mssp_pkg::cmd_type  cmd;
   mssp_pkg::stat_type stat;

   logic                          out_free;
   logic [mssp_pkg::STATUS_W-1:0] res_status;
   logic [IDX_W-1:0]              res_index;
   logic [CNT_W-1:0]              res_total;
   logic                          res_done;

   logic                          rsp_valid_ff;
   logic [mssp_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [IDX_W-1:0]              rsp_index_ff;
   logic [CNT_W-1:0]              rsp_total_ff;
   logic                          rsp_done_ff;

   // configuration registers; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.box_width     <= mssp_pkg::BOX_WIDTH_RST;
         cfg_ff.box_height    <= mssp_pkg::BOX_HEIGHT_RST;
         cfg_ff.min_sep_sq    <= mssp_pkg::MIN_SEP_SQ_RST;
         cfg_ff.attempt_limit <= mssp_pkg::ATTEMPT_LIMIT_RST;
         cfg_ff.target_count  <= mssp_pkg::TARGET_COUNT_RST;
      end else if (csr_we) begin
         case (csr_index)
            mssp_pkg::CSR_BOX_WIDTH:     cfg_ff.box_width     <= csr_wdata[15:0];
            mssp_pkg::CSR_BOX_HEIGHT:    cfg_ff.box_height    <= csr_wdata[15:0];
            mssp_pkg::CSR_MIN_SEP_SQ:    cfg_ff.min_sep_sq    <= csr_wdata;
            mssp_pkg::CSR_ATTEMPT_LIMIT: cfg_ff.attempt_limit <= csr_wdata[15:0];
            mssp_pkg::CSR_TARGET_COUNT:  cfg_ff.target_count  <= csr_wdata[10:0];
            default: begin
            end
         endcase
      end
   end

   // result register frees up in the same cycle it is taken
   assign out_free = !rsp_valid_ff || rsp_tready;

   mssp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .out_free  (out_free),
      .stat      (stat),
      .cmd       (cmd)
   );

   mssp_dpath #(
      .MAX_POINTS (MAX_POINTS),
      .COORD_BITS (COORD_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .cfg        (cfg_ff),
      .in_action  (req_tuser),
      .in_x       (req_tdata[COORD_BITS-1:0]),
      .in_y       (req_tdata[2*COORD_BITS-1:COORD_BITS]),
      .stat       (stat),
      .res_status (res_status),
      .res_index  (res_index),
      .res_total  (res_total),
      .res_done   (res_done)
   );

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_status_ff <= res_status;
         rsp_index_ff  <= res_index;
         rsp_total_ff  <= res_total;
         rsp_done_ff   <= res_done;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = RSP_W'({rsp_done_ff, rsp_total_ff, rsp_index_ff});

endmodule

`default_nettype wire

// ----- rtl/mssp_ctrl.sv -----
// Sequencing state machine of the point placer: accept, scan, drain, commit.
`default_nettype none

module mssp_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic              out_free,
   input  wire mssp_pkg::stat_type stat,
   output mssp_pkg::cmd_type      cmd
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_START = 3'd1;
   localparam logic [2:0] ST_SCAN  = 3'd2;
   localparam logic [2:0] ST_DRAIN = 3'd3;
   localparam logic [2:0] ST_FIN   = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            // no transaction is taken while reset is held
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.load = 1'b1;
               state_in = ST_START;
            end
         end
         ST_START: begin
            if (stat.skip) begin
               state_in = ST_FIN;
            end else begin
               cmd.scan_start = 1'b1;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (stat.scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!stat.pipe_busy) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // a result is only formed when the output register can take it
   a_commit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> out_free)
      else $error("commit while output register is full");

   // an accepted transaction always proceeds to the start check
   a_accept_to_start: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_START))
      else $error("accepted transaction did not start");

   // a drained pipe leads straight to the finish state
   a_drain_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN && !stat.pipe_busy) |=> (state_ff == ST_FIN))
      else $error("drain did not finish");

endmodule

`default_nettype wire

// ----- rtl/mssp_dpath.sv -----
// Point store, periodic distance pipeline, placement counters and result logic.
`default_nettype none

module mssp_dpath #(
   parameter int MAX_POINTS = mssp_pkg::MAX_POINTS_DEF,
   parameter int COORD_BITS = mssp_pkg::COORD_BITS_DEF,
   localparam int IDX_W = $clog2(MAX_POINTS),
   localparam int CNT_W = $clog2(MAX_POINTS + 1)
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire mssp_pkg::cmd_type          cmd,
   input  wire mssp_pkg::cfg_type          cfg,
   input  wire logic                       in_action,
   input  wire logic [COORD_BITS-1:0]      in_x,
   input  wire logic [COORD_BITS-1:0]      in_y,
   output mssp_pkg::stat_type              stat,
   output logic [mssp_pkg::STATUS_W-1:0]   res_status,
   output logic [IDX_W-1:0]                res_index,
   output logic [CNT_W-1:0]                res_total,
   output logic                            res_done
);

   localparam int SZ_W  = (COORD_BITS > 16) ? COORD_BITS : 16;
   localparam int D_W   = SZ_W + 2;
   localparam int SQ_W  = 2 * D_W;
   localparam int SUM_W = SQ_W + 1;

   // current transaction
   logic                  action_ff;
   logic [COORD_BITS-1:0] cand_x_ff;
   logic [COORD_BITS-1:0] cand_y_ff;

   // point store
   logic [COORD_BITS-1:0] stx_mem [MAX_POINTS];
   logic [COORD_BITS-1:0] sty_mem [MAX_POINTS];

   // distance pipe
   logic [IDX_W-1:0]      scan_addr_ff;
   logic [3:0]            pipe_v_ff;
   logic [COORD_BITS-1:0] rd_x_ff;
   logic [COORD_BITS-1:0] rd_y_ff;
   logic signed [D_W-1:0] dx_ff;
   logic signed [D_W-1:0] dy_ff;
   logic signed [D_W-1:0] dx_in;
   logic signed [D_W-1:0] dy_in;
   logic signed [D_W-1:0] wx_ff;
   logic signed [D_W-1:0] wy_ff;
   logic signed [SQ_W-1:0] sqx_s;
   logic signed [SQ_W-1:0] sqy_s;
   logic [SQ_W-1:0]       sqx_ff;
   logic [SQ_W-1:0]       sqy_ff;
   logic [SUM_W-1:0]      dist_sum;
   logic                  near;
   logic                  hit_ff;

   // placement state
   logic [CNT_W-1:0]      count_ff;
   logic [CNT_W-1:0]      count_in;
   logic [15:0]           run_ff;
   logic [15:0]           run_in;
   logic [15:0]           run_inc;
   logic                  failed_ff;
   logic                  failed_in;
   logic [CNT_W-1:0]      eff_target;
   logic                  done_now;
   logic                  store_en;

   function automatic logic signed [D_W-1:0] wrap_axis(input logic signed [D_W-1:0] d,
                                                        input logic [15:0] size);
      logic signed [D_W:0] d_ext;
      logic signed [D_W:0] twice;
      logic signed [D_W:0] s_pos;
      logic signed [D_W:0] r;
      d_ext = d;
      twice = d_ext <<< 1;
      s_pos = $signed((D_W + 1)'(size));
      if (twice > s_pos) begin
         r = d_ext - s_pos;
      end else if (twice < -s_pos) begin
         r = d_ext + s_pos;
      end else begin
         r = d_ext;
      end
      return $signed(r[D_W-1:0]);
   endfunction

   // transaction capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= in_action;
         cand_x_ff <= in_x;
         cand_y_ff <= in_y;
      end
   end

   // store: one write at commit, one registered read per scan step
   always_ff @(posedge clock) begin
      if (store_en) begin
         stx_mem[count_ff[IDX_W-1:0]] <= cand_x_ff;
         sty_mem[count_ff[IDX_W-1:0]] <= cand_y_ff;
      end
      if (cmd.scan_step) begin
         rd_x_ff <= stx_mem[scan_addr_ff];
         rd_y_ff <= sty_mem[scan_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_addr_ff <= '0;
      end else if (cmd.scan_start) begin
         scan_addr_ff <= '0;
      end else if (cmd.scan_step) begin
         scan_addr_ff <= scan_addr_ff + IDX_W'(1);
      end
   end

   assign stat.scan_last = ((CNT_W'(scan_addr_ff) + CNT_W'(1)) == count_ff);
   assign stat.pipe_busy = |pipe_v_ff;

   // read -> difference -> minimum image -> squares -> compare
   assign dx_in = $signed(D_W'(cand_x_ff)) - $signed(D_W'(rd_x_ff));
   assign dy_in = $signed(D_W'(cand_y_ff)) - $signed(D_W'(rd_y_ff));
   assign sqx_s = wx_ff * wx_ff;
   assign sqy_s = wy_ff * wy_ff;
   assign dist_sum = SUM_W'(sqx_ff) + SUM_W'(sqy_ff);
   assign near = (dist_sum < SUM_W'(cfg.min_sep_sq));

   always_ff @(posedge clock) begin
      dx_ff  <= dx_in;
      dy_ff  <= dy_in;
      wx_ff  <= wrap_axis(dx_ff, cfg.box_width);
      wy_ff  <= wrap_axis(dy_ff, cfg.box_height);
      sqx_ff <= unsigned'(sqx_s);
      sqy_ff <= unsigned'(sqy_s);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pipe_v_ff <= '0;
         hit_ff    <= 1'b0;
      end else begin
         pipe_v_ff <= {pipe_v_ff[2:0], cmd.scan_step};
         if (cmd.load) begin
            hit_ff <= 1'b0;
         end else if (pipe_v_ff[3] && near) begin
            hit_ff <= 1'b1;
         end
      end
   end

   // effective target = min(target_count, MAX_POINTS)
   always_comb begin
      if (32'(cfg.target_count) < 32'(MAX_POINTS)) begin
         eff_target = CNT_W'(cfg.target_count);
      end else begin
         eff_target = CNT_W'(MAX_POINTS);
      end
   end

   assign done_now  = (count_ff >= eff_target);
   assign stat.skip = action_ff | failed_ff | done_now | (count_ff == '0);
   assign run_inc   = (run_ff == 16'hFFFF) ? run_ff : run_ff + 16'd1;

   // outcome of the current transaction
   always_comb begin
      count_in   = count_ff;
      run_in     = run_ff;
      failed_in  = failed_ff;
      store_en   = 1'b0;
      res_index  = '0;
      res_status = mssp_pkg::STAT_ACCEPTED;
      if (action_ff) begin
         count_in   = '0;
         run_in     = '0;
         failed_in  = 1'b0;
         res_status = mssp_pkg::STAT_CLEARED;
      end else if (failed_ff) begin
         res_status = mssp_pkg::STAT_FAILED;
      end else if (done_now) begin
         res_status = mssp_pkg::STAT_DONE;
      end else if (!hit_ff) begin
         res_index  = count_ff[IDX_W-1:0];
         store_en   = cmd.commit;
         count_in   = count_ff + CNT_W'(1);
         run_in     = '0;
      end else begin
         run_in = run_inc;
         if (run_inc >= cfg.attempt_limit) begin
            failed_in  = 1'b1;
            res_status = mssp_pkg::STAT_FAILED;
         end else begin
            res_status = mssp_pkg::STAT_REJECTED;
         end
      end
   end

   assign res_total = count_in;
   assign res_done  = (count_in >= eff_target);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         run_ff    <= '0;
         failed_ff <= 1'b0;
      end else if (cmd.commit) begin
         count_ff  <= count_in;
         run_ff    <= run_in;
         failed_ff <= failed_in;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_POINTS))
      else $error("placed count beyond store depth");

   a_commit_after_drain: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> !stat.pipe_busy)
      else $error("commit with compares still in flight");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.scan_step |-> (CNT_W'(scan_addr_ff) < count_ff))
      else $error("scan read beyond placed points");

endmodule

`default_nettype wire
